// ===== design/lprs_pkg.sv =====
// Package: shared constants, codes and types for the length-prefixed record stack.
package lprs_pkg;

   localparam int CAPACITY_DEF     = 1024;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int MAX_RECORD_DEF   = 64;

   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_PUSH  = 2'd0;
   localparam op_type OP_POP   = 2'd1;
   localparam op_type OP_PEEK  = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

endpackage

// ===== design/length_prefixed_record_stack.sv =====
// Top level: variable-length record LIFO held in one byte memory, growing downward.
//
// Input channel: a word is accepted at a clock edge with start high and busy low.
// req_op selects push byte, pop record, peek record or clear. A pushed record is
// streamed one byte per word; the word with req_first_byte set carries req_rec_len.
// Each record sits above a HEADER_BYTES header holding its length, low byte first.
// Result channel: rsp_valid marks a result for exactly one cycle; there is no
// back-pressure, the receiver must take it in that cycle.
// Timing: a push, clear or empty pop/peek result appears the cycle after its word
// is accepted. A pop or peek returns its first byte later, after a header
// read then a byte read, or after the header read alone when no byte is returned.
// A push byte is written as its word is accepted; after the first byte of a record
// the header is written one byte per cycle through the shared memory port. Pop and
// peek read the header, then return one byte per cycle through the single memory
// port; busy stays high meanwhile. Clear and an empty pop/peek leave busy low.
// Reset: synchronous; the stack comes up empty with no record open. Memory
// contents are not cleared and need no clearing pass.
module length_prefixed_record_stack #(
   parameter int CAPACITY     = lprs_pkg::CAPACITY_DEF,
   parameter int HEADER_BYTES = lprs_pkg::HEADER_BYTES_DEF,
   parameter int MAX_RECORD   = lprs_pkg::MAX_RECORD_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lprs_pkg::op_type       req_op,
   input  lprs_pkg::byte_type     req_data_byte,
   input  logic                   req_first_byte,
   input  lprs_pkg::len_type      req_rec_len,
   input  lprs_pkg::len_type      req_want_len,
   output logic                   rsp_valid,
   output lprs_pkg::byte_type     rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_last,
   output lprs_pkg::status_type   rsp_status,
   output logic                   rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = (PW > lprs_pkg::LEN_W + 1) ? PW : lprs_pkg::LEN_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HDRW = 2'd1;
   localparam logic [1:0] S_HDR  = 2'd2;
   localparam logic [1:0] S_RD   = 2'd3;

   logic [1:0]            state_ff,    state_in;
   logic [PW-1:0]         top_ff,      top_in;
   logic [PW-1:0]         wp_ff,       wp_in;
   lprs_pkg::len_type     left_ff,     left_in;
   logic                  reject_ff,   reject_in;
   logic                  is_pop_ff,   is_pop_in;
   lprs_pkg::len_type     want_ff,     want_in;
   lprs_pkg::len_type     n_ff,        n_in;
   lprs_pkg::len_type     cnt_ff,      cnt_in;
   logic [AW-1:0]         rd_addr_ff,  rd_addr_in;
   logic [AW-1:0]         hdr_addr_ff, hdr_addr_in;
   lprs_pkg::len_type     hdr_len_ff,  hdr_len_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   lprs_pkg::byte_type    rsp_byte_ff,   rsp_byte_in;
   logic                  rsp_bvalid_ff, rsp_bvalid_in;
   logic                  rsp_last_ff,   rsp_last_in;
   lprs_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_addr;
   lprs_pkg::byte_type    mem_wdata;
   lprs_pkg::byte_type    mem_rdata;

   logic                  accept;
   logic                  empty;
   logic [CW-1:0]         need;
   logic                  bad_len;
   logic [PW-1:0]         new_top;
   logic [PW-1:0]         base;
   lprs_pkg::len_type     hdr_len;
   lprs_pkg::len_type     n_calc;

   lprs_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign accept  = start && (state_ff == S_IDLE);
   assign empty   = (top_ff == PW'(CAPACITY));
   assign need    = CW'(req_rec_len) + CW'(HEADER_BYTES);
   assign bad_len = (req_rec_len == '0) ||
                    (req_rec_len > lprs_pkg::LEN_W'(MAX_RECORD)) ||
                    (CW'(top_ff) < need);
   assign new_top = PW'(CW'(top_ff) - need);
   assign base    = PW'(CW'(top_ff) + CW'(HEADER_BYTES));
   assign hdr_len = mem_rdata[lprs_pkg::LEN_W-1:0];
   assign n_calc  = (want_ff < hdr_len) ? want_ff : hdr_len;

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      wp_in         = wp_ff;
      left_in       = left_ff;
      reject_in     = reject_ff;
      is_pop_in     = is_pop_ff;
      want_in       = want_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      rd_addr_in    = rd_addr_ff;
      hdr_addr_in   = hdr_addr_ff;
      hdr_len_in    = hdr_len_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = '0;
      rsp_bvalid_in = 1'b0;
      rsp_last_in   = 1'b1;
      rsp_status_in = lprs_pkg::ST_OK;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = req_data_byte;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_op)
                  lprs_pkg::OP_PUSH: begin
                     if (req_first_byte) begin
                        if (bad_len) begin
                           reject_in     = 1'b1;
                           left_in       = (req_rec_len != '0) ?
                                           req_rec_len - 1'b1 : '0;
                           rsp_status_in = lprs_pkg::ST_FULL;
                        end else begin
                           reject_in   = 1'b0;
                           top_in      = new_top;
                           mem_we      = 1'b1;
                           mem_addr    = AW'(new_top + PW'(HEADER_BYTES));
                           wp_in       = new_top + PW'(HEADER_BYTES) + 1'b1;
                           left_in     = req_rec_len - 1'b1;
                           hdr_addr_in = AW'(new_top);
                           hdr_len_in  = req_rec_len;
                           cnt_in      = '0;
                           state_in    = S_HDRW;
                        end
                     end else if (left_ff == '0 || reject_ff) begin
                        if (left_ff != '0) begin
                           left_in = left_ff - 1'b1;
                        end
                        rsp_status_in = lprs_pkg::ST_FULL;
                     end else begin
                        mem_we   = (wp_ff < PW'(CAPACITY));
                        mem_addr = AW'(wp_ff);
                        wp_in    = wp_ff + 1'b1;
                        left_in  = left_ff - 1'b1;
                     end
                  end
                  lprs_pkg::OP_CLEAR: begin
                     left_in   = '0;
                     reject_in = 1'b0;
                     top_in    = PW'(CAPACITY);
                  end
                  default: begin
                     left_in   = '0;
                     reject_in = 1'b0;
                     if (empty) begin
                        rsp_status_in = lprs_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_re       = 1'b1;
                        mem_addr     = AW'(top_ff);
                        is_pop_in    = (req_op == lprs_pkg::OP_POP);
                        want_in      = req_want_len;
                        state_in     = S_HDR;
                     end
                  end
               endcase
            end
         end
         S_HDRW: begin
            // length in the low header byte, zeros above
            mem_we      = 1'b1;
            mem_addr    = hdr_addr_ff;
            mem_wdata   = (cnt_ff == '0) ? lprs_pkg::BYTE_W'(hdr_len_ff) : '0;
            hdr_addr_in = hdr_addr_ff + 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == lprs_pkg::LEN_W'(HEADER_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            if (is_pop_ff) begin
               top_in = PW'(CW'(base) + CW'(hdr_len));
            end
            n_in   = n_calc;
            cnt_in = '0;
            if (n_calc == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               mem_re     = 1'b1;
               mem_addr   = AW'(base);
               rd_addr_in = AW'(base) + 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = mem_rdata;
            rsp_bvalid_in = 1'b1;
            rsp_last_in   = (cnt_ff + 1'b1 == n_ff);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == n_ff) begin
               state_in = S_IDLE;
            end else begin
               mem_re     = 1'b1;
               mem_addr   = rd_addr_ff;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= PW'(CAPACITY);
         wp_ff        <= '0;
         left_ff      <= '0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         wp_ff        <= wp_in;
         left_ff      <= left_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_pop_ff     <= is_pop_in;
      want_ff       <= want_in;
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      rd_addr_ff    <= rd_addr_in;
      hdr_addr_ff   <= hdr_addr_in;
      hdr_len_ff    <= hdr_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_empty   = empty;

endmodule

// ===== design/lprs_mem.sv =====
// Single-port byte memory with registered read data.
module lprs_mem #(
   parameter int DEPTH = lprs_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  lprs_pkg::byte_type       wdata,
   output lprs_pkg::byte_type       rdata
);

   lprs_pkg::byte_type mem [DEPTH];
   lprs_pkg::byte_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
